FILE: hw/rtl/vehicle_lamp_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// Lamp sequencer assertion macros
// Concurrent assertion helpers on clk_i, with and without reset disable.
// ----------------------------------------------------------------------------
`ifndef VEHICLE_LAMP_SEQUENCER_TOP_DEFINES_SVH
`define VEHICLE_LAMP_SEQUENCER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define VLS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lamp sequencer assertion failed");
`define VLS_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("lamp sequencer assertion failed");
`else
`define VLS_ASSERT(lbl, prop)
`define VLS_ASSERT_NORST(lbl, prop)
`endif

`endif

FILE: hw/rtl/vls_pkg.sv
// ----------------------------------------------------------------------------
// Lamp sequencer package
// Register defaults, register indexes, turn phase codes and config type.
// ----------------------------------------------------------------------------
package vls_pkg;

  // Default geometry
  localparam int TURN_LEDS_DEFAULT   = 16;
  localparam int FLASH_SLOTS_DEFAULT = 15;
  localparam int FADE_STEPS_DEFAULT  = 10;

  // Register indexes
  localparam logic [2:0] REG_TURN_STEP  = 3'd0;
  localparam logic [2:0] REG_FLASH_SLOT = 3'd1;
  localparam logic [2:0] REG_FADE_STEP  = 3'd2;
  localparam logic [2:0] REG_REARM      = 3'd3;
  localparam logic [2:0] REG_LIT_LEVEL  = 3'd4;

  // Register reset values
  localparam logic [7:0]  TURN_STEP_RST  = 8'd16;
  localparam logic [7:0]  FLASH_SLOT_RST = 8'd45;
  localparam logic [9:0]  FADE_STEP_RST  = 10'd101;
  localparam logic [15:0] REARM_RST      = 16'd10000;
  localparam logic [7:0]  LIT_LEVEL_RST  = 8'd80;

  // Turn phase codes, also the turn_mode output encoding
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FILL  = 2'd1;
  localparam logic [1:0] PH_CLEAR = 2'd2;

  typedef struct packed {
    logic [7:0]  turn_step_ms;
    logic [7:0]  flash_slot_ms;
    logic [9:0]  fade_step_ms;
    logic [15:0] rearm_ms;
    logic [7:0]  lit_level;
  } cfg_t;

endpackage

FILE: hw/rtl/vls_cfg_regs.sv
// ----------------------------------------------------------------------------
// Lamp sequencer configuration registers
// Range-checked register file; writes outside a register's range are dropped.
// ----------------------------------------------------------------------------
module vls_cfg_regs
  import vls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [2:0]  wr_index_i,
  input  logic [15:0] wr_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        REG_TURN_STEP: begin
          if (wr_data_i != '0 && wr_data_i <= 16'd255) cfg_d.turn_step_ms = wr_data_i[7:0];
        end
        REG_FLASH_SLOT: begin
          if (wr_data_i != '0 && wr_data_i <= 16'd255) cfg_d.flash_slot_ms = wr_data_i[7:0];
        end
        REG_FADE_STEP: begin
          if (wr_data_i != '0 && wr_data_i <= 16'd1023) cfg_d.fade_step_ms = wr_data_i[9:0];
        end
        REG_REARM: begin
          if (wr_data_i != '0) cfg_d.rearm_ms = wr_data_i;
        end
        REG_LIT_LEVEL: begin
          if (wr_data_i <= 16'd255) cfg_d.lit_level = wr_data_i[7:0];
        end
        default: begin
          // unknown index: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turn_step_ms  <= TURN_STEP_RST;
      cfg_q.flash_slot_ms <= FLASH_SLOT_RST;
      cfg_q.fade_step_ms  <= FADE_STEP_RST;
      cfg_q.rearm_ms      <= REARM_RST;
      cfg_q.lit_level     <= LIT_LEVEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/vls_turn.sv
// ----------------------------------------------------------------------------
// Lamp sequencer turn channel
// Fill sweep then clear sweep over the strip; a started cycle always finishes.
// ----------------------------------------------------------------------------
module vls_turn
  import vls_pkg::*;
#(
  parameter int TurnLeds = TURN_LEDS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       level_i,
  input  logic [7:0] step_ms_i,
  output logic [1:0] mode_o,
  output logic [7:0] head_o
);

  localparam logic [8:0] LedCount = 9'(TurnLeds);

  logic [1:0] phase_q, phase_d, phase_a;
  logic [7:0] head_q, head_d, head_a;
  logic [7:0] timer_q, timer_d, timer_a, timer_inc;

  always_comb begin
    phase_a = phase_q;
    head_a  = head_q;
    timer_a = timer_q;
    if (phase_q == PH_IDLE && level_i) begin
      phase_a = PH_FILL;
      head_a  = '0;
      timer_a = '0;
    end

    phase_d   = phase_a;
    head_d    = head_a;
    timer_d   = timer_a;
    timer_inc = timer_a + 8'd1;
    mode_o    = PH_IDLE;
    head_o    = '0;

    if (phase_a != PH_IDLE) begin
      mode_o  = phase_a;
      head_o  = head_a;
      timer_d = timer_inc;
      // advance the head when the step time is used up (or the timer wrapped)
      if (timer_inc >= step_ms_i || timer_inc == '0) begin
        timer_d = '0;
        if ({1'b0, head_a} + 9'd1 >= LedCount) begin
          head_d  = '0;
          phase_d = (phase_a == PH_FILL) ? PH_CLEAR : PH_IDLE;
        end else begin
          head_d = head_a + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      head_q  <= '0;
      timer_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      head_q  <= head_d;
      timer_q <= timer_d;
    end
  end

endmodule

FILE: hw/rtl/vls_stop.sv
// ----------------------------------------------------------------------------
// Lamp sequencer stop channel
// Armed flash burst on press, steady light after, rearm timer after release.
// ----------------------------------------------------------------------------
module vls_stop
  import vls_pkg::*;
#(
  parameter int FlashSlots = FLASH_SLOTS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        level_i,
  input  logic [7:0]  slot_ms_i,
  input  logic [15:0] rearm_ms_i,
  input  logic [7:0]  lit_level_i,
  output logic [7:0]  brightness_o
);

  localparam logic [4:0] SlotCount = 5'(FlashSlots);

  logic [3:0]  slot_q, slot_d;
  logic [7:0]  timer_q, timer_d, timer_inc;
  logic        armed_q, armed_d;
  logic        running_q, running_d;
  logic        pend_q, pend_d;
  logic [15:0] cnt_q, cnt_d;

  always_comb begin
    slot_d    = slot_q;
    timer_d   = timer_q;
    armed_d   = armed_q;
    running_d = running_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;

    // rearm countdown
    if (cnt_q != '0) begin
      cnt_d = cnt_q - 16'd1;
      if (cnt_q == 16'd1) begin
        armed_d = 1'b1;
        pend_d  = 1'b1;
      end
    end

    if (!running_q && level_i && armed_d) begin
      running_d = 1'b1;
      slot_d    = '0;
      timer_d   = '0;
      pend_d    = 1'b1;
    end

    timer_inc    = timer_d + 8'd1;
    brightness_o = '0;

    if (running_d) begin
      brightness_o = slot_d[0] ? lit_level_i : 8'd0;
      if (timer_inc >= slot_ms_i || timer_inc == '0) begin
        timer_d = '0;
        if ({1'b0, slot_d} + 5'd1 >= SlotCount) begin
          slot_d    = '0;
          running_d = 1'b0;
          armed_d   = 1'b0;
        end else begin
          slot_d = slot_d + 4'd1;
        end
      end else begin
        timer_d = timer_inc;
      end
    end else if (level_i) begin
      brightness_o = lit_level_i;
    end else if (pend_d) begin
      // first release tick: start the rearm timer
      cnt_d  = rearm_ms_i;
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      timer_q   <= '0;
      armed_q   <= 1'b1;
      running_q <= 1'b0;
      pend_q    <= 1'b1;
      cnt_q     <= '0;
    end else if (step_i) begin
      slot_q    <= slot_d;
      timer_q   <= timer_d;
      armed_q   <= armed_d;
      running_q <= running_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/vls_run.sv
// ----------------------------------------------------------------------------
// Lamp sequencer running-light channel
// Stepped fade-in of 25 per step, then full brightness while the input holds.
// ----------------------------------------------------------------------------
module vls_run
  import vls_pkg::*;
#(
  parameter int FadeSteps = FADE_STEPS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       level_i,
  input  logic [9:0] step_ms_i,
  output logic [7:0] brightness_o
);

  localparam logic [4:0] StepCount = 5'(FadeSteps);

  logic       pend_q, pend_d;
  logic [3:0] fstep_q, fstep_d;
  logic [9:0] timer_q, timer_d, timer_inc;
  logic [8:0] fade_lvl;

  assign fade_lvl  = 9'(fstep_q) * 9'd25;
  assign timer_inc = timer_q + 10'd1;

  always_comb begin
    pend_d       = pend_q;
    fstep_d      = fstep_q;
    timer_d      = timer_q;
    brightness_o = '0;

    if (pend_q && (level_i || fstep_q != '0 || timer_q != '0)) begin
      brightness_o = fade_lvl[8] ? 8'hFF : fade_lvl[7:0];
      if (timer_inc >= step_ms_i) begin
        timer_d = '0;
        if ({1'b0, fstep_q} + 5'd1 >= StepCount) begin
          fstep_d = '0;
          pend_d  = 1'b0;
        end else begin
          fstep_d = fstep_q + 4'd1;
        end
      end else begin
        timer_d = timer_inc;
      end
    end else if (!pend_q && level_i) begin
      brightness_o = 8'hFF;
    end else begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b1;
      fstep_q <= '0;
      timer_q <= '0;
    end else if (step_i) begin
      pend_q  <= pend_d;
      fstep_q <= fstep_d;
      timer_q <= timer_d;
    end
  end

endmodule

FILE: hw/rtl/vehicle_lamp_sequencer_top.sv
// ----------------------------------------------------------------------------
// Vehicle lamp sequencer
// Turn sweep, stop flash and running-light fade driven by millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request per millisecond tick on the input channel (in_valid_i /
//   in_stall_o) carrying the turn, stop and run input levels. Each tick gives
//   exactly one result on the output channel (out_valid_o / out_stall_i):
//   turn strip mode and head index, stop and running strip brightness.
//   A request is captured into an input register, evaluated combinationally
//   against the channel state and written to the result register. One
//   request per cycle is sustained while the receiver does not stall; the
//   input register frees as soon as the result register can load.
//   When the receiver stalls, the result holds and the input register keeps
//   one waiting request, after which in_stall_o rises.
//   The user must make configuration writes (cfg_valid_i, always ready) only
//   while no request is in flight (not enforced by the block). Out-of-range
//   values and unknown indexes are dropped. Reset clears both registers' valid
//   flags, idles and arms the channels and loads the register defaults.
// ----------------------------------------------------------------------------
`include "vehicle_lamp_sequencer_top_defines.svh"

module vehicle_lamp_sequencer_top
  import vls_pkg::*;
#(
  parameter int TurnLeds   = TURN_LEDS_DEFAULT,
  parameter int FlashSlots = FLASH_SLOTS_DEFAULT,
  parameter int FadeSteps  = FADE_STEPS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        turn_level_i,
  input  logic        stop_level_i,
  input  logic        run_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  turn_mode_o,
  output logic [7:0]  turn_head_o,
  output logic [7:0]  stop_brightness_o,
  output logic [7:0]  run_brightness_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg;

  logic in_valid_q, in_valid_d;
  logic turn_q, stop_q, run_q;
  logic out_valid_q, out_valid_d;
  logic accept, advance;

  logic [1:0] mode;
  logic [7:0] head, stop_b, run_b;
  logic [1:0] mode_q;
  logic [7:0] head_q, stop_b_q, run_b_q;

  assign cfg_ready_o = 1'b1;

  vls_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      turn_q <= turn_level_i;
      stop_q <= stop_level_i;
      run_q  <= run_level_i;
    end
  end

  vls_turn #(
    .TurnLeds (TurnLeds)
  ) u_turn (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .level_i   (turn_q),
    .step_ms_i (cfg.turn_step_ms),
    .mode_o    (mode),
    .head_o    (head)
  );

  vls_stop #(
    .FlashSlots (FlashSlots)
  ) u_stop (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .level_i      (stop_q),
    .slot_ms_i    (cfg.flash_slot_ms),
    .rearm_ms_i   (cfg.rearm_ms),
    .lit_level_i  (cfg.lit_level),
    .brightness_o (stop_b)
  );

  vls_run #(
    .FadeSteps (FadeSteps)
  ) u_run (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .level_i      (run_q),
    .step_ms_i    (cfg.fade_step_ms),
    .brightness_o (run_b)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_q   <= mode;
      head_q   <= head;
      stop_b_q <= stop_b;
      run_b_q  <= run_b;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign turn_mode_o       = mode_q;
  assign turn_head_o       = head_q;
  assign stop_brightness_o = stop_b_q;
  assign run_brightness_o  = run_b_q;

  // a waiting request is never dropped before it is evaluated
  `VLS_ASSERT(a_in_hold, in_valid_q && !advance |=> in_valid_q)
  // every evaluated request lands in the result register
  `VLS_ASSERT(a_adv_out, advance |=> out_valid_q)
  // a stalled result is not overwritten
  `VLS_ASSERT(a_no_overrun, out_valid_q && out_stall_i |-> !advance)
  // idle turn strip reports head zero
  `VLS_ASSERT(a_idle_head, out_valid_q && mode_q == PH_IDLE |-> head_q == 8'd0)

endmodule

FILE: test/vehicle_lamp_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// Lamp sequencer testbench
// Drives millisecond ticks with random gaps against a receiver that stalls at
// random, predicts turn, stop and run strip outputs per tick, and compares
// every result in order. Register settings change between phases.
// ----------------------------------------------------------------------------
module vehicle_lamp_sequencer_top_tb;
  import vls_pkg::*;

  localparam int FADE_INC       = 25;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 120;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic turn;
    logic stop;
    logic run;
  } tick_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] head;
    logic [7:0] stop_b;
    logic [7:0] run_b;
  } lamp_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        turn_level_i = 1'b0;
  logic        stop_level_i = 1'b0;
  logic        run_level_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  turn_mode_o;
  logic [7:0]  turn_head_o;
  logic [7:0]  stop_brightness_o;
  logic [7:0]  run_brightness_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = 3'd0;
  logic [15:0] cfg_data_i = 16'd0;

  vehicle_lamp_sequencer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .turn_level_i      (turn_level_i),
    .stop_level_i      (stop_level_i),
    .run_level_i       (run_level_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .turn_mode_o       (turn_mode_o),
    .turn_head_o       (turn_head_o),
    .stop_brightness_o (stop_brightness_o),
    .run_brightness_o  (run_brightness_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  tick_t     tick_q[$];
  lamp_out_t lamp_exp_q[$];
  tick_t     tick_cur;
  int        n_ticks_taken = 0;
  int        n_faults = 0;

  // Shadow registers and channel state
  cfg_t        lamp_cfg;
  logic [1:0]  turn_ph;
  logic [7:0]  sweep_pos;
  logic [7:0]  turn_tmr;
  logic [3:0]  slot_idx;
  logic [7:0]  flash_tmr;
  logic        flash_armed;
  logic        flashing;
  logic        rearm_pend;
  logic [15:0] rearm_cnt;
  logic        fade_pend;
  logic [3:0]  fade_idx;
  logic [9:0]  fade_tmr;

  function automatic void reset_lamp_model();
    lamp_cfg.turn_step_ms  = TURN_STEP_RST;
    lamp_cfg.flash_slot_ms = FLASH_SLOT_RST;
    lamp_cfg.fade_step_ms  = FADE_STEP_RST;
    lamp_cfg.rearm_ms      = REARM_RST;
    lamp_cfg.lit_level     = LIT_LEVEL_RST;
    turn_ph     = PH_IDLE;
    sweep_pos   = 8'd0;
    turn_tmr    = 8'd0;
    slot_idx    = 4'd0;
    flash_tmr   = 8'd0;
    flash_armed = 1'b1;
    flashing    = 1'b0;
    rearm_pend  = 1'b1;
    rearm_cnt   = 16'd0;
    fade_pend   = 1'b1;
    fade_idx    = 4'd0;
    fade_tmr    = 10'd0;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      REG_TURN_STEP:  if (val >= 1 && val <= 255) lamp_cfg.turn_step_ms = val[7:0];
      REG_FLASH_SLOT: if (val >= 1 && val <= 255) lamp_cfg.flash_slot_ms = val[7:0];
      REG_FADE_STEP:  if (val >= 1 && val <= 1023) lamp_cfg.fade_step_ms = val[9:0];
      REG_REARM:      if (val >= 1) lamp_cfg.rearm_ms = val;
      REG_LIT_LEVEL:  if (val <= 255) lamp_cfg.lit_level = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic lamp_out_t advance_lamps(tick_t t);
    lamp_out_t o;
    int        lvl;
    // turn strip: a started fill and clear pair always completes
    if (turn_ph == PH_IDLE && t.turn) begin
      turn_ph   = PH_FILL;
      sweep_pos = 8'd0;
      turn_tmr  = 8'd0;
    end
    if (turn_ph == PH_IDLE) begin
      o.mode = PH_IDLE;
      o.head = 8'd0;
    end else begin
      o.mode   = turn_ph;
      o.head   = sweep_pos;
      turn_tmr = turn_tmr + 8'd1;
      if (turn_tmr >= lamp_cfg.turn_step_ms || turn_tmr == 8'd0) begin
        turn_tmr = 8'd0;
        if (int'(sweep_pos) + 1 >= TURN_LEDS_DEFAULT) begin
          sweep_pos = 8'd0;
          turn_ph   = (turn_ph == PH_FILL) ? PH_CLEAR : PH_IDLE;
        end else begin
          sweep_pos = sweep_pos + 8'd1;
        end
      end
    end

    // rearm countdown runs regardless of the pedal
    if (rearm_cnt != 16'd0) begin
      rearm_cnt = rearm_cnt - 16'd1;
      if (rearm_cnt == 16'd0) begin
        flash_armed = 1'b1;
        rearm_pend  = 1'b1;
      end
    end

    if (!flashing && t.stop && flash_armed) begin
      flashing   = 1'b1;
      slot_idx   = 4'd0;
      flash_tmr  = 8'd0;
      rearm_pend = 1'b1;
    end
    if (flashing) begin
      o.stop_b  = slot_idx[0] ? lamp_cfg.lit_level : 8'd0;
      flash_tmr = flash_tmr + 8'd1;
      if (flash_tmr >= lamp_cfg.flash_slot_ms || flash_tmr == 8'd0) begin
        flash_tmr = 8'd0;
        slot_idx  = slot_idx + 4'd1;
        if (int'(slot_idx) >= FLASH_SLOTS_DEFAULT) begin
          slot_idx    = 4'd0;
          flashing    = 1'b0;
          flash_armed = 1'b0;
        end
      end
    end else if (t.stop) begin
      o.stop_b = lamp_cfg.lit_level;
    end else begin
      o.stop_b = 8'd0;
      if (rearm_pend) begin
        rearm_cnt  = lamp_cfg.rearm_ms;
        rearm_pend = 1'b0;
      end
    end

    // run strip: a started fade finishes even if the input drops
    if (fade_pend && (t.run || fade_idx != 4'd0 || fade_tmr != 10'd0)) begin
      lvl = int'(fade_idx) * FADE_INC;
      if (lvl > 255) lvl = 255;
      o.run_b  = lvl[7:0];
      fade_tmr = fade_tmr + 10'd1;
      if (fade_tmr >= lamp_cfg.fade_step_ms) begin
        fade_tmr = 10'd0;
        fade_idx = fade_idx + 4'd1;
        if (int'(fade_idx) >= FADE_STEPS_DEFAULT) begin
          fade_idx  = 4'd0;
          fade_pend = 1'b0;
        end
      end
    end else if (!fade_pend && t.run) begin
      o.run_b = 8'd255;
    end else begin
      o.run_b   = 8'd0;
      fade_pend = 1'b1;
    end
    return o;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Tick driver
  int tx_wait = 0;
  bit tx_burst = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        lamp_exp_q.push_back(advance_lamps(tick_cur));
        n_ticks_taken++;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        tx_wait = tx_burst ? 0 : $urandom_range(0, 10);
      end
      // hold a stalled request, otherwise advance
      if (!in_valid_i || !in_stall_o) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() > 0) begin
          tick_cur = tick_q.pop_front();
          turn_level_i <= tick_cur.turn;
          stop_level_i <= tick_cur.stop;
          run_level_i  <= tick_cur.run;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off so the input side backs up
  logic hold_active = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_active <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      hold_active <= (hold_left > 0);
    end else if (!hold_done && n_ticks_taken >= 250 && tick_q.size() > 20) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      hold_active <= 1'b1;
    end
  end

  // Result monitor
  int rx_wait = 0;
  bit rx_burst = 1'b0;

  always @(posedge clk_i) begin
    lamp_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (lamp_exp_q.size() == 0) begin
          n_faults++;
          if (n_faults <= MAX_REPORTS)
            $display("unexpected result: mode %0d head %0d stop %0d run %0d",
                     turn_mode_o, turn_head_o, stop_brightness_o, run_brightness_o);
        end else begin
          want = lamp_exp_q.pop_front();
          if (turn_mode_o !== want.mode || turn_head_o !== want.head ||
              stop_brightness_o !== want.stop_b || run_brightness_o !== want.run_b) begin
            n_faults++;
            if (n_faults <= MAX_REPORTS)
              $display("mismatch: expected mode %0d head %0d stop %0d run %0d, got mode %0d head %0d stop %0d run %0d",
                       want.mode, want.head, want.stop_b, want.run_b,
                       turn_mode_o, turn_head_o, stop_brightness_o, run_brightness_o);
          end
        end
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 10);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= (rx_wait > 0) || hold_active;
    end
  end

  // Watchdog on cycles without any handshake
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_lamp_regs(logic [15:0] step, logic [15:0] slot, logic [15:0] fade,
                               logic [15:0] rearm, logic [15:0] lit);
    write_reg(REG_TURN_STEP, step);
    write_reg(REG_FLASH_SLOT, slot);
    write_reg(REG_FADE_STEP, fade);
    write_reg(REG_REARM, rearm);
    write_reg(REG_LIT_LEVEL, lit);
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || in_valid_i || lamp_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_ticks(logic t, logic s, logic r, int count);
    tick_t k;
    k.turn = t;
    k.stop = s;
    k.run  = r;
    repeat (count) tick_q.push_back(k);
  endtask

  // Mostly held levels of random length, with bursts of per-tick noise
  task automatic queue_random_ticks(int count);
    tick_t k;
    int    len;
    while (count > 0) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : $urandom_range(1, 15);
      if (len > count) len = count;
      k = tick_t'($urandom_range(0, 7));
      if (len <= 6 && $urandom_range(0, 1) == 1) begin
        repeat (len) tick_q.push_back(tick_t'($urandom_range(0, 7)));
      end else begin
        repeat (len) tick_q.push_back(k);
      end
      count -= len;
    end
  endtask

  initial begin
    reset_lamp_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values
    push_ticks(1'b0, 1'b0, 1'b0, 1);
    push_ticks(1'b1, 1'b1, 1'b1, 1);
    push_ticks(1'b0, 1'b1, 1'b1, 1);
    push_ticks(1'b1, 1'b0, 1'b0, 1);
    wait_idle();

    // drop out-of-range values and unknown indexes
    write_reg(REG_TURN_STEP, 16'd0);
    write_reg(REG_TURN_STEP, 16'd256);
    write_reg(REG_FLASH_SLOT, 16'd0);
    write_reg(REG_FLASH_SLOT, 16'd300);
    write_reg(REG_FADE_STEP, 16'd0);
    write_reg(REG_FADE_STEP, 16'd1024);
    write_reg(REG_REARM, 16'd0);
    write_reg(REG_LIT_LEVEL, 16'd256);
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd6, 16'h0001);
    write_reg(3'd7, 16'h8000);
    set_lamp_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd255);

    // short pulses: sweeps, flash and fade finish after release
    push_ticks(1'b1, 1'b1, 1'b1, 1);
    push_ticks(1'b0, 1'b0, 1'b0, 14);
    push_ticks(1'b0, 1'b1, 1'b0, 4);
    push_ticks(1'b0, 1'b0, 1'b1, 2);
    queue_random_ticks(130);
    wait_idle();

    set_lamp_regs(16'd2, 16'd3, 16'd2, 16'd20, 16'($urandom_range(0, 255)));
    queue_random_ticks(130);
    wait_idle();

    set_lamp_regs(16'd255, 16'd255, 16'd1023, 16'd65535, 16'd0);
    queue_random_ticks(60);
    wait_idle();

    set_lamp_regs(16'($urandom_range(1, 3)), 16'($urandom_range(1, 4)),
                  16'($urandom_range(1, 6)), 16'($urandom_range(1, 50)),
                  16'($urandom_range(0, 255)));
    queue_random_ticks(130);
    wait_idle();

    set_lamp_regs(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 12)), 16'($urandom_range(1, 200)),
                  16'($urandom_range(0, 255)));
    queue_random_ticks(130);
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (n_faults == 0 && lamp_exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: vehicle_lamp_sequencer_top.f
+incdir+hw/rtl
hw/rtl/vls_pkg.sv
hw/rtl/vls_cfg_regs.sv
hw/rtl/vls_turn.sv
hw/rtl/vls_stop.sv
hw/rtl/vls_run.sv
hw/rtl/vehicle_lamp_sequencer_top.sv
test/vehicle_lamp_sequencer_top_tb.sv
